// ===== hdl/urba_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// urba_pkg
// shared constants, register indexes and the band lookup for the range band
// announcer
// ----------------------------------------------------------------------------
package urba_pkg;

  localparam int COUNT_W     = 16;
  localparam int DIST_W      = 16;
  localparam int THRESH_W    = 10;
  localparam int SETTLE_W    = 4;
  localparam int SCALE_W     = 16;
  localparam int BAND_W      = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int OUT_DATA_W  = 24;

  localparam int BAND_COUNT = 11;
  localparam int BAND_START = 25;
  localparam int BAND_WIDTH = 50;
  localparam int BAND_END   = BAND_START + BAND_COUNT * BAND_WIDTH;

  localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(50);
  localparam logic [SETTLE_W-1:0] SETTLE_RESET = SETTLE_W'(2);
  localparam logic [SCALE_W-1:0]  SCALE_RESET  = SCALE_W'(1209);
  localparam logic [SETTLE_W-1:0] COUNTER_MAX  = {SETTLE_W{1'b1}};

  localparam logic [CFG_INDEX_W-1:0] REG_CHANGE_THRESHOLD = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_COUNT     = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_SCALE_FACTOR     = CFG_INDEX_W'(2);

  // band 1..BAND_COUNT covers 50 cm steps from 25 cm, 0 when outside;
  // counts how many band lower edges the distance has passed
  function automatic logic [BAND_W-1:0] band_of(input logic [DIST_W-1:0] dist_cm);
    logic [BAND_W-1:0] band;
    int                k;
    band = '0;
    for (k = 0; k < BAND_COUNT; k++) begin
      if (dist_cm >= DIST_W'(BAND_START + k * BAND_WIDTH)) begin
        band = band + BAND_W'(1);
      end
    end
    if (dist_cm >= DIST_W'(BAND_END)) begin
      band = '0;
    end
    return band;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/urba_scale.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// urba_scale
// capture count to centimetre scaling, one registered multiply
// ----------------------------------------------------------------------------
module urba_scale
  import urba_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                load,
  input  wire logic [COUNT_W-1:0]  capture_count,
  input  wire logic [SCALE_W-1:0]  scale_factor,
  output logic      [DIST_W-1:0]   distance_cm
);

  logic [COUNT_W+SCALE_W-1:0] product;

  // unsigned q0.16 scale, keep the integer part
  assign product = COUNT_W'(capture_count) * SCALE_W'(scale_factor);

  always_ff @(posedge clk) begin
    if (load) begin
      distance_cm <= product[COUNT_W+SCALE_W-1 -: DIST_W];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/ultrasonic_range_band_announcer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ultrasonic_range_band_announcer
// scales echo captures to cm, tracks a held distance with settling, and
// flags a new 50 cm band once the reading has settled
// ----------------------------------------------------------------------------
// an accepted request moves from the multiply stage to the result register
// throughput: one request per cycle; the multiply stage and the tracking
//   stage each hold one request, stalls ripple back through tready
// reset: rst (synchronous, high) empties both stages, returns the registers
//   to threshold 50 cm, settle count 2, scale 1209, and clears the tracker
// ----------------------------------------------------------------------------
module ultrasonic_range_band_announcer
  import urba_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  // capture input
  input  wire logic                    s_tvalid,
  output logic                         s_tready,
  input  wire logic [COUNT_W-1:0]      s_tdata,    // [15:0] capture_count
  // result output
  output logic                         m_tvalid,
  input  wire logic                    m_tready,
  output logic      [OUT_DATA_W-1:0]   m_tdata,    // [15:0] distance_cm,
                                                   // [16] announce,
                                                   // [20:17] band, [23:21] zero
  // register writes
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data
);

  // configuration registers
  logic [THRESH_W-1:0] change_threshold;
  logic [SETTLE_W-1:0] settle_count;
  logic [SCALE_W-1:0]  scale_factor;

  // pipeline control
  logic scale_valid;
  logic out_valid;
  logic out_advance;
  logic scale_advance;
  logic in_accept;
  logic track_load;

  // scaled distance from the multiply stage
  logic [DIST_W-1:0] scale_dist;

  // tracker state
  logic [DIST_W-1:0]   held_distance;
  logic                change_pending;
  logic [SETTLE_W-1:0] stable_counter;
  logic [BAND_W-1:0]   announced_band;

  logic [DIST_W-1:0]   held_distance_next;
  logic                change_pending_next;
  logic [SETTLE_W-1:0] stable_counter_next;
  logic [BAND_W-1:0]   announced_band_next;

  logic [DIST_W:0]     diff;
  logic                changed;
  logic                classify;
  logic [BAND_W-1:0]   band_next;
  logic                announce_next;

  // result register
  logic [DIST_W-1:0] out_distance;
  logic              out_announce;
  logic [BAND_W-1:0] out_band;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      change_threshold <= THRESH_RESET;
      settle_count     <= SETTLE_RESET;
      scale_factor     <= SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CHANGE_THRESHOLD: change_threshold <= cfg_data[THRESH_W-1:0];
        REG_SETTLE_COUNT:     settle_count     <= cfg_data[SETTLE_W-1:0];
        REG_SCALE_FACTOR:     scale_factor     <= cfg_data[SCALE_W-1:0];
        default:              ;  // unknown index, write dropped
      endcase
    end
  end

  // a stage moves when the one after it is empty or moving
  assign out_advance   = !out_valid || m_tready;
  assign scale_advance = !scale_valid || out_advance;
  assign s_tready      = scale_advance;
  assign in_accept     = s_tvalid && s_tready;
  assign track_load    = scale_valid && out_advance;

  urba_scale u_scale (
    .clk           (clk),
    .load          (in_accept),
    .capture_count (s_tdata),
    .scale_factor  (scale_factor),
    .distance_cm   (scale_dist)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (scale_advance) begin
        scale_valid <= s_tvalid;
      end
      if (out_advance) begin
        out_valid <= scale_valid;
      end
    end
  end

  // true absolute difference against the held distance
  assign diff    = (scale_dist > held_distance)
                   ? ({1'b0, scale_dist} - {1'b0, held_distance})
                   : ({1'b0, held_distance} - {1'b0, scale_dist});
  assign changed = diff > (DIST_W + 1)'(change_threshold);

  always_comb begin
    held_distance_next  = held_distance;
    change_pending_next = change_pending;
    stable_counter_next = stable_counter;
    announced_band_next = announced_band;
    band_next           = '0;
    announce_next       = 1'b0;
    classify            = 1'b0;

    if (changed) begin
      // new reading, restart settling
      held_distance_next  = scale_dist;
      change_pending_next = 1'b1;
      stable_counter_next = '0;
    end else if (stable_counter != COUNTER_MAX) begin
      stable_counter_next = stable_counter + SETTLE_W'(1);
    end

    // settled after a change: sort the held distance into its band
    classify = change_pending_next && (stable_counter_next >= settle_count);
    if (classify) begin
      band_next = band_of(held_distance_next);
      // out of range never announced, same band not repeated
      if (band_next != '0 && band_next != announced_band) begin
        announce_next       = 1'b1;
        announced_band_next = band_next;
      end
      change_pending_next = 1'b0;
      stable_counter_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_distance  <= '0;
      change_pending <= 1'b0;
      stable_counter <= '0;
      announced_band <= '0;
    end else if (track_load) begin
      held_distance  <= held_distance_next;
      change_pending <= change_pending_next;
      stable_counter <= stable_counter_next;
      announced_band <= announced_band_next;
    end
  end

  always_ff @(posedge clk) begin
    if (track_load) begin
      out_distance <= scale_dist;
      out_announce <= announce_next;
      out_band     <= band_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {(OUT_DATA_W - DIST_W - 1 - BAND_W)'(0), out_band, out_announce,
                     out_distance};

endmodule
`default_nettype wire

// ===== tb/ultrasonic_range_band_announcer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ultrasonic_range_band_announcer_tb
// streams echo captures into the band announcer and checks every result
// against a cycle-free tracker of held distance, settling and band
// announcements; covers band edges, settle limits, register masking,
// ignored register writes, random dwell sequences and output backpressure
// ----------------------------------------------------------------------------
module ultrasonic_range_band_announcer_tb;
  import urba_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = CFG_INDEX_W'(3);
  localparam int DRAIN_CYCLES   = 6;
  localparam int RUN_LIMIT_NS   = 400_000;
  localparam int PHASE_ITEMS    = 52;
  localparam int PHASE_COUNT    = 7;
  localparam int HOLDOFF_LEN    = 300;
  localparam int PRESSURE_ITEMS = 40;
  localparam int MAX_PRINTED    = 50;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_t;

  typedef struct {
    logic [DIST_W-1:0] distance;
    logic              announce;
    logic [BAND_W-1:0] band;
  } range_reading_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  wire                    s_tready;
  logic [COUNT_W-1:0]     s_tdata   = '0;   // [15:0] capture_count
  wire                    m_tvalid;
  logic                   m_tready  = 1'b0;
  wire  [OUT_DATA_W-1:0]  m_tdata;          // [15:0] distance_cm, [16] announce,
                                            // [20:17] band, [23:21] zero
  logic                   cfg_valid = 1'b0;
  wire                    cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  // tracker copy of registers and state
  logic [THRESH_W-1:0] thr_reg        = THRESH_RESET;
  logic [SETTLE_W-1:0] settle_reg     = SETTLE_RESET;
  logic [SCALE_W-1:0]  scale_reg      = SCALE_RESET;
  logic [DIST_W-1:0]   held_cm        = '0;
  logic                change_pending = 1'b0;
  logic [SETTLE_W-1:0] settle_ctr     = '0;
  logic [BAND_W-1:0]   last_band      = '0;

  range_reading_t expected_readings[$];
  range_reading_t oldest_reading;

  int       mismatches     = 0;
  int       result_index   = 0;
  int       burst_left     = 0;
  int       holdoff_cycles = 0;
  int       rx_tick        = 0;
  int       stall_pct      = 0;
  rx_mode_t rx_mode        = RX_OPEN;

  ultrasonic_range_band_announcer dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------- tracker

  function automatic logic [BAND_W-1:0] band_for(input logic [DIST_W-1:0] cm);
    if (cm < BAND_START || cm >= BAND_END) begin
      return '0;
    end
    return BAND_W'((cm - BAND_START) / BAND_WIDTH + 1);
  endfunction

  // advances the tracker by one capture and returns the result it causes
  function automatic range_reading_t track_capture(input logic [COUNT_W-1:0] count);
    logic [31:0]       product;
    logic [DIST_W-1:0] cm;
    logic [DIST_W-1:0] delta;
    range_reading_t    r;
    product    = count * scale_reg;
    cm         = product[31:16];
    delta      = (cm > held_cm) ? cm - held_cm : held_cm - cm;
    r.distance = cm;
    r.announce = 1'b0;
    r.band     = '0;
    if (delta > DIST_W'(thr_reg)) begin
      held_cm        = cm;
      change_pending = 1'b1;
      settle_ctr     = '0;
    end else if (settle_ctr != COUNTER_MAX) begin
      settle_ctr = settle_ctr + 1'b1;
    end
    if (change_pending && settle_ctr >= settle_reg) begin
      r.band = band_for(held_cm);
      if (r.band != '0 && r.band != last_band) begin
        last_band  = r.band;
        r.announce = 1'b1;
      end
      change_pending = 1'b0;
      settle_ctr     = '0;
    end
    return r;
  endfunction

  // capture count that lands near a wanted distance at the current scale
  function automatic logic [COUNT_W-1:0] count_for_distance(input int cm);
    longint c;
    if (scale_reg == '0) begin
      return COUNT_W'($urandom());
    end
    c = ((longint'(cm) << 16) + scale_reg - 1) / scale_reg;
    if (c > 65535) begin
      c = 65535;
    end
    return COUNT_W'(c);
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      s_tvalid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // one capture request; bursts of random length, random gaps between them
  task automatic send_capture(input logic [COUNT_W-1:0] count);
    s_tvalid <= 1'b1;
    s_tdata  <= count;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_readings.push_back(track_capture(count));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(15);
      pause_sender(($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6));
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0]  value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (index)
      REG_CHANGE_THRESHOLD: thr_reg    = value[THRESH_W-1:0];
      REG_SETTLE_COUNT:     settle_reg = value[SETTLE_W-1:0];
      REG_SCALE_FACTOR:     scale_reg  = value[SCALE_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // receiver: open, random or periodic stalls, plus a long hold-off on demand
  always @(posedge clk) begin
    rx_tick++;
    if (rx_tick % 64 == 0) begin
      rx_mode   = rx_mode_t'($urandom_range(2));
      stall_pct = $urandom_range(10, 85);
    end
    if (holdoff_cycles > 0) begin
      holdoff_cycles--;
      m_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:   m_tready <= 1'b1;
        RX_RANDOM: m_tready <= ($urandom_range(99) >= stall_pct);
        default:   m_tready <= ((rx_tick % 8) < 5);
      endcase
    end
  end

  // ---------------------------------------------------------------- checker

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < MAX_PRINTED) begin
      $display("mismatch on result %0d: %s got %0d, want %0d", result_index, what, got,
               want);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_readings.size() == 0) begin
        report_mismatch("unexpected result, distance", m_tdata[15:0], -1);
      end else begin
        oldest_reading = expected_readings.pop_front();
        if (m_tdata[15:0] !== oldest_reading.distance) begin
          report_mismatch("distance_cm", m_tdata[15:0], oldest_reading.distance);
        end
        if (m_tdata[16] !== oldest_reading.announce) begin
          report_mismatch("announce", m_tdata[16], oldest_reading.announce);
        end
        if (m_tdata[20:17] !== oldest_reading.band) begin
          report_mismatch("band", m_tdata[20:17], oldest_reading.band);
        end
      end
      result_index++;
    end
  end

  // ---------------------------------------------------------------- tests

  // reset register values: about 100 cm settles into band 2 after two repeats
  task automatic test_reset_values();
    repeat (3) send_capture(COUNT_W'(5421));
    wait_drained();
  endtask

  // unit scale so distance is count-1; zero settle classifies in the same step
  task automatic test_band_edges();
    write_register(REG_CHANGE_THRESHOLD, '0);
    write_register(REG_SETTLE_COUNT, '0);
    write_register(REG_SCALE_FACTOR, '1);
    send_capture(COUNT_W'(25));      // just below the first band
    send_capture(COUNT_W'(26));      // lower edge of band 1
    send_capture(COUNT_W'(75));      // same band again, no announce
    send_capture(COUNT_W'(76));      // lower edge of band 2
    send_capture(COUNT_W'(575));     // top of the last band
    send_capture(COUNT_W'(576));     // just past the last band, kept band
    send_capture(COUNT_W'(575));     // back to the announced band
    send_capture(COUNT_W'(65535));   // largest capture
    send_capture(COUNT_W'(1));       // zero distance
    wait_drained();
  endtask

  // oversized threshold write is masked to 1023; largest settle count
  task automatic test_settle_limit();
    int k;
    write_register(REG_CHANGE_THRESHOLD, '1);
    write_register(REG_SETTLE_COUNT, '1);
    send_capture(COUNT_W'(1100));
    for (k = 0; k < 15; k++) begin
      send_capture(COUNT_W'(1100 + $urandom_range(0, 500)));
    end
    wait_drained();
  endtask

  task automatic test_zero_scale();
    write_register(REG_SCALE_FACTOR, '0);
    repeat (2) send_capture(COUNT_W'($urandom()));
    wait_drained();
  endtask

  // writes to the unused index must leave every register alone
  task automatic test_ignored_register();
    write_register(REG_UNUSED, '1);
    write_register(REG_UNUSED, '0);
    write_register(REG_SCALE_FACTOR, SCALE_RESET);
    repeat (2) send_capture(COUNT_W'($urandom()));
    wait_drained();
  endtask

  // per phase a new setting, then dwell sequences around random distances
  // mixed with raw noise captures
  task automatic test_random_phases();
    int                  phase;
    int                  sent;
    int                  reps;
    int                  k;
    int                  target;
    logic [COUNT_W-1:0]  count;
    logic [CFG_DATA_W-1:0] thr_w;
    logic [CFG_DATA_W-1:0] settle_w;
    logic [CFG_DATA_W-1:0] scale_w;
    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          thr_w    = '0;
          settle_w = '0;
          scale_w  = '1;
        end
        1: begin
          thr_w    = CFG_DATA_W'(1023);
          settle_w = CFG_DATA_W'(15);
          scale_w  = SCALE_RESET;
        end
        default: begin
          case ($urandom_range(3))
            0:       thr_w = CFG_DATA_W'($urandom_range(0, 15));
            1:       thr_w = CFG_DATA_W'($urandom_range(16, 150));
            2:       thr_w = CFG_DATA_W'($urandom_range(0, 1023));
            default: thr_w = CFG_DATA_W'($urandom());
          endcase
          settle_w = ($urandom_range(3) == 0) ? CFG_DATA_W'($urandom())
                                              : CFG_DATA_W'($urandom_range(0, 15));
          scale_w  = ($urandom_range(4) == 0) ? CFG_DATA_W'($urandom())
                                              : CFG_DATA_W'($urandom_range(400, 12000));
        end
      endcase
      write_register(REG_CHANGE_THRESHOLD, thr_w);
      write_register(REG_SETTLE_COUNT, settle_w);
      write_register(REG_SCALE_FACTOR, scale_w);
      write_register(REG_UNUSED, CFG_DATA_W'($urandom()));
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(4) == 0) begin
          send_capture(COUNT_W'($urandom()));
          sent++;
        end else begin
          target = ($urandom_range(9) == 0) ? $urandom_range(576, 4000)
                                            : $urandom_range(0, 620);
          reps   = $urandom_range(1, settle_reg + 3);
          count  = count_for_distance(target);
          for (k = 0; k < reps; k++) begin
            send_capture(count + COUNT_W'($urandom_range(0, 2)));
            sent++;
          end
        end
      end
    end
    wait_drained();
  endtask

  // receiver holds off while captures keep coming, so the input stalls
  task automatic test_output_backpressure();
    int k;
    write_register(REG_CHANGE_THRESHOLD, CFG_DATA_W'(20));
    write_register(REG_SETTLE_COUNT, CFG_DATA_W'(1));
    write_register(REG_SCALE_FACTOR, SCALE_RESET);
    holdoff_cycles = HOLDOFF_LEN;
    burst_left     = PRESSURE_ITEMS;
    for (k = 0; k < PRESSURE_ITEMS; k++) begin
      send_capture(count_for_distance($urandom_range(0, 620)));
    end
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_band_edges();
    test_settle_limit();
    test_zero_scale();
    test_ignored_register();
    test_random_phases();
    test_output_backpressure();
    wait_drained();
    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(RUN_LIMIT_NS);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
